// File: rtl/bchc_pkg.sv
// Shared types and constants for the button click/hold classifier.
// No dependencies; used by the top level, its port checker and the testbench.
package bchc_pkg;

  localparam int unsigned Buttons = 4;   // buttons served, at most 4 (2-bit index)
  localparam int unsigned TimeW   = 32;  // millisecond timestamp width
  localparam int unsigned CfgW    = 16;  // width of every config register

  typedef logic [TimeW-1:0] time_ms_t;
  typedef logic [CfgW-1:0]  cfg_ms_t;
  typedef logic [1:0]       btn_idx_t;

  // Per-button click progress; numbering is part of the event encoding.
  typedef enum logic [2:0] {
    PhIdle       = 3'd0,
    PhFirstPress = 3'd1,
    PhFirstRel   = 3'd2,
    PhSecPress   = 3'd3,
    PhSecRel     = 3'd4,
    PhThirdPress = 3'd5,
    PhThirdRel   = 3'd6,
    PhHeld       = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    EvSingle    = 3'd0,
    EvDouble    = 3'd1,
    EvTriple    = 3'd2,
    EvHoldStart = 3'd3,
    EvLongHold  = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    CfgDebounce = 2'd0,
    CfgClickGap = 2'd1,
    CfgHold     = 2'd2,
    CfgLongHold = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FuncEdge = 1'b0,
    FuncPoll = 1'b1
  } func_e;

endpackage

// File: rtl/button_click_hold_classifier.sv
// Top level of the button click/hold classifier: input register, per-button
// state, classify/update logic and output register. Depends on bchc_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o| func_i button_i level_i now_ms_i
//  out     | source    | out_valid_o/out_stall_i| button_out_o event_res_o elapsed_ms_o
//  cfg     | sink      | cfg_we_i (no wait)     | cfg_idx_i cfg_data_i
//
// Each word passes the input register, then the compare/update logic into the
// output register. A new word is accepted every cycle while the output is not
// stalled; the per-button state is read and written in the same stage, so
// back-to-back words on one button see each other.
// Reset (async, active low) clears phases to idle, timestamps to zero and the
// config registers to 50/300/500/3000 ms.
// A stalled result blocks only the stage behind it once that stage is full;
// edge words and polls without an event still need that stage to drain.
module button_click_hold_classifier (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  bchc_pkg::btn_idx_t  button_i,
  input  logic                level_i,
  input  bchc_pkg::time_ms_t  now_ms_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bchc_pkg::btn_idx_t  button_out_o,
  output logic [2:0]          event_res_o,
  output bchc_pkg::time_ms_t  elapsed_ms_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  bchc_pkg::cfg_ms_t   cfg_data_i
);
  import bchc_pkg::*;

  // config registers
  cfg_ms_t debounce_q, click_gap_q, hold_q, long_hold_q;

  // input register
  logic     in_vld_q;
  logic     func_q;
  btn_idx_t btn_q;
  logic     level_q;
  time_ms_t now_q;

  // per-button state
  phase_e   phase_q [Buttons];
  time_ms_t last_q  [Buttons];

  // output register
  logic     out_vld_q, out_vld_d;
  btn_idx_t out_btn_q;
  event_e   out_ev_q, ev_d;
  time_ms_t out_elapsed_q;

  logic     advance;      // compute stage hands its word on this cycle
  logic     in_range;
  phase_e   ph_cur, ph_d;
  time_ms_t elapsed;
  logic     fire;
  logic     upd_phase, upd_time;

  // strict "elapsed > cfg" with a 16-bit threshold
  function automatic logic over(input time_ms_t el, input cfg_ms_t lim);
    over = (el[TimeW-1:CfgW] != '0) || (el[CfgW-1:0] > lim);
  endfunction

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= CfgW'(50);
      click_gap_q <= CfgW'(300);
      hold_q      <= CfgW'(500);
      long_hold_q <= CfgW'(3000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgDebounce: debounce_q  <= cfg_data_i;
        CfgClickGap: click_gap_q <= cfg_data_i;
        CfgHold:     hold_q      <= cfg_data_i;
        CfgLongHold: long_hold_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q  <= func_i;
      btn_q   <= button_i;
      level_q <= level_i;
      now_q   <= now_ms_i;
    end
  end

  // classify / update
  assign in_range = 32'(btn_q) < Buttons;
  assign ph_cur   = phase_q[btn_q];
  assign elapsed  = now_q - last_q[btn_q];

  always_comb begin
    ph_d      = ph_cur;
    ev_d      = EvSingle;
    fire      = 1'b0;
    upd_time  = 1'b0;
    upd_phase = 1'b0;
    if (in_range) begin
      unique case (func_e'(func_q))
        FuncEdge: begin
          upd_time  = 1'b1;
          upd_phase = 1'b1;
          if (over(elapsed, debounce_q)) begin
            // even phase waits for a press (level 0), odd for a release
            priority if (ph_cur < PhThirdRel && ph_cur[0] == level_q) begin
              ph_d = phase_e'(ph_cur + 3'd1);
            end else if (level_q && ph_cur == PhHeld) begin
              ph_d = PhIdle;
            end else begin
              ph_d = ph_cur;
            end
          end
        end
        FuncPoll: begin
          unique case (ph_cur)
            PhFirstRel, PhSecRel, PhThirdRel: begin
              if (over(elapsed, click_gap_q)) begin
                fire      = 1'b1;
                upd_phase = 1'b1;
                ph_d      = PhIdle;
                // phase 2/4/6 -> single/double/triple
                ev_d      = event_e'(3'(ph_cur[2:1] - 2'd1));
              end
            end
            PhFirstPress: begin
              if (over(elapsed, hold_q)) begin
                fire      = 1'b1;
                upd_phase = 1'b1;
                ph_d      = PhHeld;
                ev_d      = EvHoldStart;
              end
            end
            PhHeld: begin
              if (over(elapsed, long_hold_q)) begin
                fire      = 1'b1;
                upd_phase = 1'b1;
                ph_d      = PhIdle;
                ev_d      = EvLongHold;
              end
            end
            default: ;  // idle, second and third press have no timeout
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '{default: PhIdle};
      last_q  <= '{default: '0};
    end else if (advance) begin
      if (upd_phase) phase_q[btn_q] <= ph_d;
      if (upd_time)  last_q[btn_q]  <= now_q;
    end
  end

  // output register
  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (advance) out_vld_d = fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fire) begin
      out_btn_q     <= btn_q;
      out_ev_q      <= ev_d;
      out_elapsed_q <= elapsed;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign button_out_o = out_btn_q;
  assign event_res_o  = out_ev_q;
  assign elapsed_ms_o = out_elapsed_q;

endmodule

// File: rtl/bchc_checker.sv
// Port-level checks for the button click/hold classifier, bound to the top.
// Depends on bchc_pkg and the top level's port list.
module bchc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                func_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bchc_pkg::btn_idx_t  button_out_o,
  input logic [2:0]          event_res_o,
  input bchc_pkg::time_ms_t  elapsed_ms_o
);
  import bchc_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(button_out_o)
      && $stable(event_res_o) && $stable(elapsed_ms_o))
    else $error("stalled result word changed");

  // with the output free the block never stalls its input
  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output was free");

  // a new result follows an accepted poll word
  a_res_from_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && func_i == FuncPoll, 2))
    else $error("result without a preceding poll word");

  // results only name served buttons
  a_btn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(button_out_o) < Buttons)
    else $error("result for an unserved button");

endmodule

bind button_click_hold_classifier bchc_checker u_bchc_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_click_hold_classifier: a scoreboard class
// predicts the click/hold events, plain tasks drive the word and config ports.
// Depends on bchc_pkg and the top-level RTL only.

import bchc_pkg::*;

// One predicted result word.
typedef struct packed {
  btn_idx_t button;
  event_e   ev;
  time_ms_t elapsed;
} click_event_t;

// Tracks per-button click phase and last-change time, predicts the event that
// each accepted word causes and compares result words against them in order.
class click_scoreboard;
  cfg_ms_t      timing [4];
  phase_e       phase [Buttons];
  time_ms_t     last_edge [Buttons];
  click_event_t pending_events [$];
  int unsigned  mismatches;

  function new();
    timing[CfgDebounce] = 16'd50;
    timing[CfgClickGap] = 16'd300;
    timing[CfgHold]     = 16'd500;
    timing[CfgLongHold] = 16'd3000;
    foreach (phase[b]) begin
      phase[b]     = PhIdle;
      last_edge[b] = '0;
    end
    mismatches = 0;
  endfunction

  function void set_timing(cfg_idx_e idx, cfg_ms_t val);
    timing[idx] = val;
  endfunction

  function int unsigned pending();
    return pending_events.size();
  endfunction

  // Apply one accepted word to the state; queue the event a poll reports.
  function void note_word(func_e f, btn_idx_t b, logic lvl, time_ms_t now);
    phase_e       ph;
    time_ms_t     since;
    click_event_t want;
    bit           fires;
    if (int'(b) >= Buttons) return;
    ph    = phase[b];
    since = now - last_edge[b];
    fires = 1'b0;
    if (f == FuncEdge) begin
      // press advances an even phase, release an odd one, up to third release
      if (since > timing[CfgDebounce]) begin
        if (ph < PhThirdRel && ph[0] == lvl) ph = phase_e'(ph + 3'd1);
        else if (lvl && ph == PhHeld) ph = PhIdle;
      end
      phase[b]     = ph;
      last_edge[b] = now;  // restamped even when bouncing
      return;
    end
    case (ph)
      PhFirstRel, PhSecRel, PhThirdRel: begin
        if (since > timing[CfgClickGap]) begin
          fires   = 1'b1;
          want.ev = (ph == PhFirstRel) ? EvSingle : (ph == PhSecRel) ? EvDouble : EvTriple;
          phase[b] = PhIdle;
        end
      end
      PhFirstPress: begin
        if (since > timing[CfgHold]) begin
          fires    = 1'b1;
          want.ev  = EvHoldStart;
          phase[b] = PhHeld;
        end
      end
      PhHeld: begin
        if (since > timing[CfgLongHold]) begin
          fires    = 1'b1;
          want.ev  = EvLongHold;
          phase[b] = PhIdle;
        end
      end
      default: ;  // idle, second and third presses never time out
    endcase
    if (fires) begin
      want.button  = b;
      want.elapsed = since;
      pending_events.push_back(want);
    end
  endfunction

  function void check_result(btn_idx_t b, logic [2:0] ev, time_ms_t el);
    click_event_t want;
    if (pending_events.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: btn %0d event %0d elapsed %0d", b, ev, el);
      return;
    end
    want = pending_events.pop_front();
    if (b !== want.button || ev !== want.ev || el !== want.elapsed) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected btn %0d event %0d elapsed %0d, ",
                  "got btn %0d event %0d elapsed %0d"},
                 want.button, want.ev, want.elapsed, b, ev, el);
    end
  endfunction
endclass

module testbench;

  localparam int unsigned DrainCycles = 4;     // pipeline is two stages deep
  localparam int unsigned QuietLimit  = 2000;  // cycles with no handshake at all
  localparam int unsigned IdlePct     = 34;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall_o;
  func_e    func = FuncEdge;
  btn_idx_t button = '0;
  logic     level = 1'b1;
  time_ms_t now_ms = '0;
  logic     out_valid_o;
  logic     out_stall = 1'b0;
  btn_idx_t button_out_o;
  logic [2:0] event_res_o;
  time_ms_t elapsed_ms_o;
  logic     cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CfgDebounce;
  cfg_ms_t  cfg_data = '0;

  click_scoreboard sb;
  bit          no_idle = 1'b0;      // calm stretch: neither side idles
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  time_ms_t    t_ms = 32'h0000_0400; // running timestamp for generated gestures

  button_click_hold_classifier u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .func_i       (func),
    .button_i     (button),
    .level_i      (level),
    .now_ms_i     (now_ms),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .button_out_o (button_out_o),
    .event_res_o  (event_res_o),
    .elapsed_ms_o (elapsed_ms_o),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random back-pressure, except in the calm stretch.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < IdlePct);
  end

  // Monitor: both handshakes are sampled at the edge, before any new drive.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) sb.note_word(func, button, level, now_ms);
      if (out_valid_o && !out_stall)
        sb.check_result(button_out_o, event_res_o, elapsed_ms_o);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a stuck handshake ends the run.
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  // Present one word, with random idle cycles ahead of it, and hold it
  // until the block takes it. Returns at the accepting edge.
  task automatic send_word(func_e f, btn_idx_t b, logic lvl, time_ms_t now);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    button   <= b;
    level    <= lvl;
    now_ms   <= now;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    words_sent++;
  endtask

  // Step the gesture clock forward and send a word stamped with it.
  task automatic advance(func_e f, btn_idx_t b, logic lvl, time_ms_t delta);
    t_ms = t_ms + delta;
    send_word(f, b, lvl, t_ms);
  endtask

  // Sender stops until every predicted event is out, then lets the pipe empty
  // of edge words and silent polls.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write all four timing registers, one per cycle; block must be idle.
  task automatic program_timing(cfg_ms_t deb_ms, cfg_ms_t gap_ms, cfg_ms_t hold_ms,
                                cfg_ms_t long_ms);
    cfg_ms_t vals [4];
    vals = '{deb_ms, gap_ms, hold_ms, long_ms};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_idx_e'(i);
      cfg_data <= vals[i];
      sb.set_timing(cfg_idx_e'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // A delay around a threshold: mostly just past it, sometimes exactly on it
  // (strict compare, so nothing happens), sometimes short of it.
  function automatic time_ms_t past(cfg_ms_t thr);
    time_ms_t base;
    time_ms_t d;
    base = time_ms_t'(thr);
    case ($urandom_range(9))
      0: d = base - 1;  // wraps to a huge delay when thr is zero
      1: d = base;
      2: d = $urandom_range(0, thr);
      default: d = base + $urandom_range(1, 40);
    endcase
    return d;
  endfunction

  // Well-formed press/release sequence on one button with random timing:
  // one to four clicks, optional bounce, optional hold on the first press.
  task automatic gesture(btn_idx_t b);
    int unsigned presses;
    bit          holding;
    presses = $urandom_range(1, 4);
    holding = ($urandom_range(3) == 0);
    for (int i = 0; i < presses; i++) begin
      advance(FuncEdge, b, 1'b0, past(sb.timing[CfgDebounce]));
      if ($urandom_range(4) == 0)  // bounce inside the debounce window
        advance(FuncEdge, b, 1'($urandom_range(1)),
                $urandom_range(0, sb.timing[CfgDebounce]));
      if ($urandom_range(5) == 0)
        advance(FuncPoll, b, 1'($urandom_range(1)), past(sb.timing[CfgClickGap]));
      if (holding && i == 0) begin
        advance(FuncPoll, b, 1'($urandom_range(1)), past(sb.timing[CfgHold]));
        if ($urandom_range(1))
          advance(FuncEdge, b, 1'b0, past(sb.timing[CfgDebounce]));  // press while held
        advance(FuncPoll, b, 1'($urandom_range(1)), past(sb.timing[CfgLongHold]));
      end
      if (!(holding && i == 0) || $urandom_range(1))
        advance(FuncEdge, b, 1'b1, past(sb.timing[CfgDebounce]));
    end
    advance(FuncPoll, b, 1'($urandom_range(1)), past(sb.timing[CfgClickGap]));
    if ($urandom_range(1))
      advance(FuncPoll, b, 1'($urandom_range(1)), past(sb.timing[CfgClickGap]));
  endtask

  // Any word at all: full-range timestamps, sometimes moving the gesture clock.
  task automatic noise();
    time_ms_t now;
    now = $urandom_range(1) ? time_ms_t'($urandom) : t_ms + $urandom_range(0, 200);
    if ($urandom_range(1)) t_ms = now;
    send_word(func_e'($urandom_range(1)), btn_idx_t'($urandom_range(Buttons - 1)),
              1'($urandom_range(1)), now);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset timing (50/300/500/3000 ms).
    send_word(FuncEdge, 2'd1, 1'b0, 32'd0);      // inside debounce of reset stamp
    send_word(FuncEdge, 2'd0, 1'b0, 32'd100);
    send_word(FuncEdge, 2'd0, 1'b1, 32'd200);
    send_word(FuncPoll, 2'd0, 1'b0, 32'd500);    // gap exactly reached: nothing
    send_word(FuncPoll, 2'd0, 1'b1, 32'd501);    // single click
    send_word(FuncEdge, 2'd2, 1'b0, 32'd1000);
    send_word(FuncPoll, 2'd2, 1'b0, 32'd1501);   // hold start
    send_word(FuncEdge, 2'd2, 1'b0, 32'd1600);   // press while held: restamp only
    send_word(FuncPoll, 2'd2, 1'b0, 32'd4601);   // long hold
    send_word(FuncEdge, 2'd3, 1'b0, 32'd5000);
    send_word(FuncEdge, 2'd3, 1'b1, 32'd5100);
    send_word(FuncEdge, 2'd3, 1'b0, 32'd5200);
    send_word(FuncEdge, 2'd3, 1'b1, 32'd5300);
    send_word(FuncEdge, 2'd3, 1'b0, 32'd5400);
    send_word(FuncEdge, 2'd3, 1'b1, 32'd5500);
    send_word(FuncEdge, 2'd3, 1'b0, 32'd5600);   // after third release: ignored
    send_word(FuncPoll, 2'd3, 1'b0, 32'd5901);   // triple click
    send_word(FuncEdge, 2'd1, 1'b0, 32'd7000);
    send_word(FuncEdge, 2'd1, 1'b1, 32'd7100);
    send_word(FuncEdge, 2'd1, 1'b0, 32'd7200);
    send_word(FuncPoll, 2'd1, 1'b0, 32'd20000);  // second press held: no timeout
    send_word(FuncEdge, 2'd1, 1'b1, 32'd20100);
    send_word(FuncPoll, 2'd1, 1'b0, 32'd20401);  // double click
    send_word(FuncEdge, 2'd0, 1'b0, 32'hFFFF_FFC0);
    send_word(FuncEdge, 2'd0, 1'b1, 32'h0000_0010);  // elapsed across the wrap
    send_word(FuncPoll, 2'd0, 1'b1, 32'hFFFF_FFFF);  // single click, wrapped elapsed
    drain();

    // Random phases, each under its own timing; phase 3 runs without idling.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_timing(cfg_ms_t'($urandom_range(0, 60)),
                          cfg_ms_t'($urandom_range(0, 400)),
                          cfg_ms_t'($urandom_range(0, 600)),
                          cfg_ms_t'($urandom_range(0, 4000)));
        1: program_timing(16'd0, 16'd0, 16'd0, 16'd0);
        2: program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_timing(cfg_ms_t'($urandom), cfg_ms_t'($urandom),
                          cfg_ms_t'($urandom), cfg_ms_t'($urandom));
        4: program_timing(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        default: program_timing(cfg_ms_t'($urandom_range(0, 100)),
                                cfg_ms_t'($urandom_range(0, 800)),
                                cfg_ms_t'($urandom_range(0, 900)),
                                cfg_ms_t'($urandom_range(0, 5000)));
      endcase
      no_idle <= (p == 3);
      while (words_sent < 26 + (p + 1) * 330) begin
        if ($urandom_range(4) != 0) gesture(btn_idx_t'($urandom_range(Buttons - 1)));
        else noise();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
